FILE: src/ppt_pkg.sv
// ---------------------------------------------------------------------------
// Planar pose transform package
// Shared widths, angle constants, the arctangent table and the pipeline
// payload types of the planar pose transform.
// ---------------------------------------------------------------------------
package ppt_pkg;

  // Field widths of the channels.
  localparam int PT_W  = 32;
  localparam int ANG_W = 16;

  // Internal datapath widths.
  localparam int DIFF_W = PT_W + 1;          // point minus reference
  localparam int CORD_W = 32;                // CORDIC vector and angle
  localparam int TRIG_W = 18;                // Q16 sine and cosine
  localparam int PROD_W = DIFF_W + TRIG_W;   // one product
  localparam int SUM_W  = PROD_W + 1;        // sum of two products
  localparam int OUT_SHIFT = 16;
  localparam int RND_W  = SUM_W - OUT_SHIFT; // rounded rotation
  localparam int OX_W   = RND_W + 1;         // rotation plus reference
  localparam int EXT_W  = 50;                // room for every clip width

  // Angle constants in 1/64 degree.
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int EIGHTH_TURN  = 2880;
  localparam int MOD_W        = 15;          // holds [0, FULL_TURN)
  localparam int R_W          = 13;          // holds [-EIGHTH_TURN, EIGHTH_TURN)

  // CORDIC constants.
  localparam int MAX_STAGES      = 32;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int TRIG_SHIFT      = 14;
  localparam int TRIG_ROUND      = 8192;
  localparam int OUT_ROUND       = 32768;

  // Direction codes.
  localparam logic FUNC_W2L = 1'b0;
  localparam logic FUNC_L2W = 1'b1;

  // atan(2^-i) in units of 2^-22 degree.
  localparam logic signed [CORD_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29,
    32'sd14,        32'sd7,         32'sd4,        32'sd2,
    32'sd1,         32'sd0,         32'sd0,        32'sd0
  };

  // Operands that travel alongside the CORDIC vector.
  typedef struct packed {
    logic                     func;
    logic [1:0]               quad;
    logic signed [DIFF_W-1:0] u;
    logic signed [DIFF_W-1:0] v;
    logic signed [PT_W-1:0]   rx;
    logic signed [PT_W-1:0]   ry;
  } ppt_side_t;

  // CORDIC vector and residual angle.
  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } ppt_vec_t;

endpackage

FILE: src/ppt_if.sv
// ---------------------------------------------------------------------------
// Planar pose transform channels
// Valid/ready channels for input points with their reference pose and for
// transformed results.
// ---------------------------------------------------------------------------
interface ppt_in_if;
  import ppt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   func;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] ref_x;
  logic signed [PT_W-1:0] ref_y;
  logic signed [ANG_W-1:0] ref_angle;

  modport source (output valid, func, point_x, point_y, ref_x, ref_y, ref_angle,
                  input ready);
  modport sink   (input valid, func, point_x, point_y, ref_x, ref_y, ref_angle,
                  output ready);
endinterface

interface ppt_out_if;
  import ppt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] out_x;
  logic signed [PT_W-1:0] out_y;
  logic                   saturated;

  modport source (output valid, out_x, out_y, saturated, input ready);
  modport sink   (input valid, out_x, out_y, saturated, output ready);
endinterface

FILE: src/ppt_prep.sv
// ---------------------------------------------------------------------------
// Planar pose transform input stage
// Reduces the heading to a quadrant and a residual angle, forms the point
// operands and registers the CORDIC start vector.
// ---------------------------------------------------------------------------
module ppt_prep (
  input  logic              clk,
  input  logic              rst_n,
  ppt_in_if.sink            in_ch,
  input  logic              rdy_out,
  output logic              v_out,
  output ppt_pkg::ppt_side_t side_out,
  output ppt_pkg::ppt_vec_t  vec_out
);
  import ppt_pkg::*;

  localparam int AW = ANG_W + 2;
  localparam logic signed [AW-1:0] TURN_A = AW'(FULL_TURN);
  localparam logic signed [AW-1:0] ZERO_A = '0;
  localparam logic [MOD_W:0] Q1_T = (MOD_W+1)'(QUARTER_TURN);
  localparam logic [MOD_W:0] Q2_T = (MOD_W+1)'(2 * QUARTER_TURN);
  localparam logic [MOD_W:0] Q3_T = (MOD_W+1)'(3 * QUARTER_TURN);
  localparam logic [MOD_W:0] Q4_T = (MOD_W+1)'(FULL_TURN);

  logic signed [AW-1:0]    ang_ext;
  logic signed [AW-1:0]    m_wide;
  logic [MOD_W-1:0]        m;
  logic [MOD_W:0]          t;
  logic [MOD_W:0]          offs;
  logic [1:0]              quad;
  logic signed [MOD_W:0]   r_wide;
  logic signed [R_W-1:0]   r;
  ppt_side_t               side_nxt;
  ppt_vec_t                vec_nxt;
  logic                    v_r;
  ppt_side_t               side_r;
  ppt_vec_t                vec_r;

  assign ang_ext = {{(AW-ANG_W){in_ch.ref_angle[ANG_W-1]}}, in_ch.ref_angle};

  // Wrap any 16-bit heading into one full turn.
  always_comb begin
    priority if (ang_ext >= TURN_A) begin
      m_wide = ang_ext - TURN_A;
    end else if (ang_ext >= ZERO_A) begin
      m_wide = ang_ext;
    end else if (ang_ext >= -TURN_A) begin
      m_wide = ang_ext + TURN_A;
    end else begin
      m_wide = ang_ext + TURN_A + TURN_A;
    end
  end

  assign m = m_wide[MOD_W-1:0];
  assign t = {1'b0, m} + (MOD_W+1)'(EIGHTH_TURN);

  // Nearest quarter turn; the top band folds back onto quadrant zero.
  always_comb begin
    priority if (t >= Q4_T) begin
      quad = 2'd0;
      offs = Q4_T;
    end else if (t >= Q3_T) begin
      quad = 2'd3;
      offs = Q3_T;
    end else if (t >= Q2_T) begin
      quad = 2'd2;
      offs = Q2_T;
    end else if (t >= Q1_T) begin
      quad = 2'd1;
      offs = Q1_T;
    end else begin
      quad = 2'd0;
      offs = '0;
    end
  end

  assign r_wide = $signed({1'b0, m}) - $signed(offs);
  assign r      = r_wide[R_W-1:0];

  always_comb begin
    side_nxt.func = in_ch.func;
    side_nxt.quad = quad;
    side_nxt.rx   = in_ch.ref_x;
    side_nxt.ry   = in_ch.ref_y;
    if (in_ch.func == FUNC_W2L) begin
      side_nxt.u = $signed({in_ch.point_x[PT_W-1], in_ch.point_x})
                 - $signed({in_ch.ref_x[PT_W-1], in_ch.ref_x});
      side_nxt.v = $signed({in_ch.point_y[PT_W-1], in_ch.point_y})
                 - $signed({in_ch.ref_y[PT_W-1], in_ch.ref_y});
    end else begin
      side_nxt.u = {in_ch.point_x[PT_W-1], in_ch.point_x};
      side_nxt.v = {in_ch.point_y[PT_W-1], in_ch.point_y};
    end
    vec_nxt.x = CORD_W'(CORDIC_GAIN_Q30);
    vec_nxt.y = '0;
    vec_nxt.z = {{(CORD_W-R_W-OUT_SHIFT){r[R_W-1]}}, r, {OUT_SHIFT{1'b0}}};
  end

  assign in_ch.ready = !v_r || rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      side_r <= side_nxt;
      vec_r  <= vec_nxt;
    end
  end

  assign v_out    = v_r;
  assign side_out = side_r;
  assign vec_out  = vec_r;

endmodule

FILE: src/ppt_cordic_stage.sv
// ---------------------------------------------------------------------------
// Planar pose transform CORDIC stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ---------------------------------------------------------------------------
module ppt_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_in,
  output logic               rdy_in,
  input  ppt_pkg::ppt_vec_t  vec_in,
  input  ppt_pkg::ppt_side_t side_in,
  output logic               v_out,
  input  logic               rdy_out,
  output ppt_pkg::ppt_vec_t  vec_out,
  output ppt_pkg::ppt_side_t side_out
);
  import ppt_pkg::*;

  localparam logic signed [CORD_W-1:0] ATAN_I = ATAN_TAB[STAGE];

  logic signed [CORD_W-1:0] xi, yi, zi, dx, dy;
  ppt_vec_t                 vec_nxt;
  logic                     v_r;
  ppt_vec_t                 vec_r;
  ppt_side_t                side_r;

  assign xi = vec_in.x;
  assign yi = vec_in.y;
  assign zi = vec_in.z;
  assign dx = yi >>> STAGE;
  assign dy = xi >>> STAGE;

  always_comb begin
    if (!zi[CORD_W-1]) begin
      vec_nxt.x = xi - dx;
      vec_nxt.y = yi + dy;
      vec_nxt.z = zi - ATAN_I;
    end else begin
      vec_nxt.x = xi + dx;
      vec_nxt.y = yi - dy;
      vec_nxt.z = zi + ATAN_I;
    end
  end

  assign rdy_in = !v_r || rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_in) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in && v_in) begin
      vec_r  <= vec_nxt;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign vec_out  = vec_r;
  assign side_out = side_r;

endmodule

FILE: src/ppt_trig.sv
// ---------------------------------------------------------------------------
// Planar pose transform sine and cosine stage
// Rounds the CORDIC vector to Q16 and turns it into the reduced quadrant.
// ---------------------------------------------------------------------------
module ppt_trig (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_in,
  output logic                          rdy_in,
  input  ppt_pkg::ppt_vec_t             vec_in,
  input  ppt_pkg::ppt_side_t            side_in,
  output logic                          v_out,
  input  logic                          rdy_out,
  output logic signed [ppt_pkg::TRIG_W-1:0] cos_out,
  output logic signed [ppt_pkg::TRIG_W-1:0] sin_out,
  output ppt_pkg::ppt_side_t            side_out
);
  import ppt_pkg::*;

  logic signed [CORD_W-1:0] xr, yr;
  logic signed [TRIG_W-1:0] c, s, cos_nxt, sin_nxt;
  logic                     v_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  ppt_side_t                side_r;

  assign xr = vec_in.x + CORD_W'(TRIG_ROUND);
  assign yr = vec_in.y + CORD_W'(TRIG_ROUND);
  assign c  = xr[TRIG_SHIFT +: TRIG_W];
  assign s  = yr[TRIG_SHIFT +: TRIG_W];

  // Each quarter turn maps (c, s) to (-s, c).
  always_comb begin
    unique case (side_in.quad)
      2'd0: begin
        cos_nxt = c;
        sin_nxt = s;
      end
      2'd1: begin
        cos_nxt = -s;
        sin_nxt = c;
      end
      2'd2: begin
        cos_nxt = -c;
        sin_nxt = -s;
      end
      default: begin
        cos_nxt = s;
        sin_nxt = -c;
      end
    endcase
  end

  assign rdy_in = !v_r || rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_in) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in && v_in) begin
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign cos_out  = cos_r;
  assign sin_out  = sin_r;
  assign side_out = side_r;

endmodule

FILE: src/ppt_combine.sv
// ---------------------------------------------------------------------------
// Planar pose transform rotation and output stages
// Multiplies the operands by sine and cosine, rounds the sums, adds the
// reference position where needed and saturates into the output register.
// ---------------------------------------------------------------------------
module ppt_combine #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              v_in,
  output logic                              rdy_in,
  input  logic signed [ppt_pkg::TRIG_W-1:0] cos_in,
  input  logic signed [ppt_pkg::TRIG_W-1:0] sin_in,
  input  ppt_pkg::ppt_side_t                side_in,
  ppt_out_if.source                         out_ch
);
  import ppt_pkg::*;

  localparam logic signed [EXT_W-1:0] HI =
    $signed((EXT_W'(1) << (COORD_WIDTH - 1)) - EXT_W'(1));
  localparam logic signed [EXT_W-1:0] LO = ~HI;

  // Multiply stage.
  logic signed [DIFF_W-1:0] u_s, v_s;
  logic signed [PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic                     m_v_r, m_rdy, m_func_r;
  logic signed [PT_W-1:0]   m_rx_r, m_ry_r;

  // Sum stage.
  logic [SUM_W-1:0]         sx_nxt, sy_nxt;
  logic signed [RND_W-1:0]  rnd_x_r, rnd_y_r;
  logic                     s_v_r, s_rdy, s_func_r;
  logic signed [PT_W-1:0]   s_rx_r, s_ry_r;

  // Output stage.
  logic signed [OX_W-1:0]   ox, oy;
  logic signed [EXT_W-1:0]  ex, ey, cx, cy;
  logic                     sat_x, sat_y;
  logic                     o_v_r, o_rdy, sat_r;
  logic signed [PT_W-1:0]   out_x_r, out_y_r;

  assign u_s = side_in.u;
  assign v_s = side_in.v;

  // The same four products serve both directions.
  assign pa_nxt = u_s * cos_in;
  assign pb_nxt = v_s * sin_in;
  assign pc_nxt = v_s * cos_in;
  assign pd_nxt = u_s * sin_in;

  always_comb begin
    if (m_func_r == FUNC_W2L) begin
      sx_nxt = {pa_r[PROD_W-1], pa_r} + {pb_r[PROD_W-1], pb_r};
      sy_nxt = {pc_r[PROD_W-1], pc_r} - {pd_r[PROD_W-1], pd_r};
    end else begin
      sx_nxt = {pa_r[PROD_W-1], pa_r} - {pb_r[PROD_W-1], pb_r};
      sy_nxt = {pd_r[PROD_W-1], pd_r} + {pc_r[PROD_W-1], pc_r};
    end
    sx_nxt = sx_nxt + SUM_W'(OUT_ROUND);
    sy_nxt = sy_nxt + SUM_W'(OUT_ROUND);
  end

  always_comb begin
    ox = {rnd_x_r[RND_W-1], rnd_x_r};
    oy = {rnd_y_r[RND_W-1], rnd_y_r};
    if (s_func_r == FUNC_L2W) begin
      ox = ox + {{(OX_W-PT_W){s_rx_r[PT_W-1]}}, s_rx_r};
      oy = oy + {{(OX_W-PT_W){s_ry_r[PT_W-1]}}, s_ry_r};
    end
    ex = {{(EXT_W-OX_W){ox[OX_W-1]}}, ox};
    ey = {{(EXT_W-OX_W){oy[OX_W-1]}}, oy};
  end

  always_comb begin
    sat_x = 1'b0;
    sat_y = 1'b0;
    cx    = ex;
    cy    = ey;
    if (ex > HI) begin
      cx    = HI;
      sat_x = 1'b1;
    end else if (ex < LO) begin
      cx    = LO;
      sat_x = 1'b1;
    end
    if (ey > HI) begin
      cy    = HI;
      sat_y = 1'b1;
    end else if (ey < LO) begin
      cy    = LO;
      sat_y = 1'b1;
    end
  end

  // Each stage moves on when it is empty or the one after it moves on.
  assign o_rdy  = !o_v_r || out_ch.ready;
  assign s_rdy  = !s_v_r || o_rdy;
  assign m_rdy  = !m_v_r || s_rdy;
  assign rdy_in = m_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (m_rdy) begin
        m_v_r <= v_in;
      end
      if (s_rdy) begin
        s_v_r <= m_v_r;
      end
      if (o_rdy) begin
        o_v_r <= s_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && v_in) begin
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      pc_r     <= pc_nxt;
      pd_r     <= pd_nxt;
      m_func_r <= side_in.func;
      m_rx_r   <= side_in.rx;
      m_ry_r   <= side_in.ry;
    end
    if (s_rdy && m_v_r) begin
      rnd_x_r  <= sx_nxt[OUT_SHIFT +: RND_W];
      rnd_y_r  <= sy_nxt[OUT_SHIFT +: RND_W];
      s_func_r <= m_func_r;
      s_rx_r   <= m_rx_r;
      s_ry_r   <= m_ry_r;
    end
    if (o_rdy && s_v_r) begin
      out_x_r <= cx[PT_W-1:0];
      out_y_r <= cy[PT_W-1:0];
      sat_r   <= sat_x || sat_y;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.saturated = sat_r;

endmodule

FILE: src/planar_pose_transform_top.sv
// ---------------------------------------------------------------------------
// Planar pose transform
// Moves a Q16.16 point between a world frame and the local frame of a
// reference pose, with CORDIC sine and cosine and saturated results.
// ---------------------------------------------------------------------------
// Stages: input, one per CORDIC iteration, trig, product, sum and output.
// Throughput: one transaction per cycle unless the output stalls; each CORDIC
// iteration has a register stage of its own, so a new point enters while
// earlier ones are in flight.
// Reset: synchronous and active low; it clears the stage valid bits only.
// ---------------------------------------------------------------------------
module planar_pose_transform_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ppt_in_if.sink    in_ch,
  ppt_out_if.source out_ch
);
  import ppt_pkg::*;

  // Every stage carries a valid bit with its data and is ready when it is
  // empty or its successor takes its contents, so bubbles close up and a
  // stalled output holds every transaction in place without loss.
  //
  // Index zero of the arrays below is the input stage; index i + 1 is the
  // output of CORDIC iteration i.
  logic      v_s   [CORDIC_STAGES+1];
  logic      rdy_s [CORDIC_STAGES+1];
  ppt_vec_t  vec_s [CORDIC_STAGES+1];
  ppt_side_t side_s[CORDIC_STAGES+1];

  logic                     trig_v, trig_rdy, comb_rdy;
  logic signed [TRIG_W-1:0] trig_cos, trig_sin;
  ppt_side_t                trig_side;

  // Input stage: heading reduced to a quadrant and a residual within one
  // eighth of a turn, the point offset formed for the world to local case,
  // and the CORDIC vector started at the inverse gain.
  ppt_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .rdy_out  (rdy_s[0]),
    .v_out    (v_s[0]),
    .side_out (side_s[0]),
    .vec_out  (vec_s[0])
  );

  // Unrolled CORDIC in rotation mode, one iteration per register stage.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    ppt_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .v_in     (v_s[g]),
      .rdy_in   (rdy_s[g]),
      .vec_in   (vec_s[g]),
      .side_in  (side_s[g]),
      .v_out    (v_s[g+1]),
      .rdy_out  (rdy_s[g+1]),
      .vec_out  (vec_s[g+1]),
      .side_out (side_s[g+1])
    );
  end

  // Sine and cosine rounded to Q16 and mapped back to the full circle. The
  // reverse direction reuses them with the sine negated in the sums.
  ppt_trig u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (v_s[CORDIC_STAGES]),
    .rdy_in   (rdy_s[CORDIC_STAGES]),
    .vec_in   (vec_s[CORDIC_STAGES]),
    .side_in  (side_s[CORDIC_STAGES]),
    .v_out    (trig_v),
    .rdy_out  (trig_rdy),
    .cos_out  (trig_cos),
    .sin_out  (trig_sin),
    .side_out (trig_side)
  );

  // Products, rounded sums, reference offset and saturation. The last of its
  // three stages is the output register.
  ppt_combine #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_in    (trig_v),
    .rdy_in  (comb_rdy),
    .cos_in  (trig_cos),
    .sin_in  (trig_sin),
    .side_in (trig_side),
    .out_ch  (out_ch)
  );

  assign trig_rdy = comb_rdy;

endmodule

FILE: src/ppt_checker.sv
// ---------------------------------------------------------------------------
// Planar pose transform checker
// Port-level assertions on transaction flow and saturated results.
// ---------------------------------------------------------------------------
module ppt_checker #(
  parameter int DEPTH       = 21,
  parameter int COORD_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic        saturated
);
  localparam int CNT_W = $clog2(DEPTH + 2);
  localparam logic [63:0] HI64 = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] LO64 = ~HI64;
  localparam logic [31:0] HI32 = HI64[31:0];
  localparam logic [31:0] LO32 = LO64[31:0];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                && $stable(saturated))
    else $error("result changed while stalled");

  // No result without an accepted transaction behind it.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a pending transaction");

  // The pipeline never holds more transactions than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("more transactions in flight than stages");

  // With the output register empty, the whole pipeline can take a point.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A saturated result sits on a clip bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> out_x == HI32 || out_x == LO32
                               || out_y == HI32 || out_y == LO32)
    else $error("saturated flag without a clipped coordinate");

endmodule

bind planar_pose_transform_top ppt_checker #(
  .DEPTH       (CORDIC_STAGES + 5),
  .COORD_WIDTH (COORD_WIDTH)
) u_ppt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .saturated (out_ch.saturated)
);

FILE: tb/planar_pose_transform_top_tb.sv
// ---------------------------------------------------------------------------
// Planar pose transform testbench
// Streams points with their reference poses into the transform in both
// directions and with random gaps on both channels. A scoreboard predicts
// every result with its own CORDIC and rounding model and compares each
// output transaction field by field, in order.
// ---------------------------------------------------------------------------
module planar_pose_transform_top_tb;
  import ppt_pkg::*;

  localparam int STAGES         = 16;
  localparam int CLIP_W         = 32;
  localparam int LATENCY        = STAGES + 5;
  localparam int RANDOM_POINTS  = 700;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDLE_PCT       = 15;

  localparam logic signed [PT_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PT_W-1:0] COORD_MIN = 32'sh8000_0000;

  // Headings in 1/64 degree.
  localparam logic signed [ANG_W-1:0] DEG_45  = 16'sd2880;
  localparam logic signed [ANG_W-1:0] DEG_90  = 16'sd5760;
  localparam logic signed [ANG_W-1:0] DEG_180 = 16'sd11520;
  localparam logic signed [ANG_W-1:0] DEG_270 = 16'sd17280;
  localparam logic signed [ANG_W-1:0] DEG_360 = 16'sd23040;

  typedef struct {
    logic                    func;
    logic signed [PT_W-1:0]  pt_x;
    logic signed [PT_W-1:0]  pt_y;
    logic signed [PT_W-1:0]  ref_x;
    logic signed [PT_W-1:0]  ref_y;
    logic signed [ANG_W-1:0] heading;
  } pose_req_t;

  typedef struct {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic                   sat;
  } pose_res_t;

  // Holds the predicted transforms of accepted points, oldest first.
  class pose_scoreboard;
    pose_res_t expected_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Bit-exact prediction of one transform.
    function pose_res_t transform(pose_req_t r);
      longint    m, q, r_ang, cx, cy, cz, dxs, dys, c, s, t, u, v, ox, oy, hi, lo;
      int        i;
      pose_res_t res;
      // Reduce the heading into [0, 360) degrees, then into a quadrant and
      // a residual of at most 45 degrees either way.
      m = longint'(r.heading) % FULL_TURN;
      if (m < 0) m += FULL_TURN;
      q     = (m + EIGHTH_TURN) / QUARTER_TURN;
      r_ang = m - q * QUARTER_TURN;
      cz    = r_ang * 65536;
      cx    = CORDIC_GAIN_Q30;
      cy    = 0;
      for (i = 0; i < STAGES && i < MAX_STAGES; i++) begin
        dxs = cy >>> i;
        dys = cx >>> i;
        if (cz >= 0) begin
          cx -= dxs;
          cy += dys;
          cz -= longint'(ATAN_TAB[i]);
        end else begin
          cx += dxs;
          cy -= dys;
          cz += longint'(ATAN_TAB[i]);
        end
      end
      c = (cx + TRIG_ROUND) >>> TRIG_SHIFT;
      s = (cy + TRIG_ROUND) >>> TRIG_SHIFT;
      repeat (q & 3) begin
        t = c;
        c = -s;
        s = t;
      end
      if (r.func == FUNC_W2L) begin
        u  = longint'(r.pt_x) - longint'(r.ref_x);
        v  = longint'(r.pt_y) - longint'(r.ref_y);
        ox = (u * c + v * s + OUT_ROUND) >>> OUT_SHIFT;
        oy = (v * c - u * s + OUT_ROUND) >>> OUT_SHIFT;
      end else begin
        u  = longint'(r.pt_x);
        v  = longint'(r.pt_y);
        ox = ((u * c - v * s + OUT_ROUND) >>> OUT_SHIFT) + longint'(r.ref_x);
        oy = ((u * s + v * c + OUT_ROUND) >>> OUT_SHIFT) + longint'(r.ref_y);
      end
      hi = (64'sd1 <<< (CLIP_W - 1)) - 1;
      lo = -hi - 1;
      res.sat = 1'b0;
      if (ox > hi) begin ox = hi; res.sat = 1'b1; end
      if (ox < lo) begin ox = lo; res.sat = 1'b1; end
      if (oy > hi) begin oy = hi; res.sat = 1'b1; end
      if (oy < lo) begin oy = lo; res.sat = 1'b1; end
      res.x = ox[PT_W-1:0];
      res.y = oy[PT_W-1:0];
      return res;
    endfunction

    function void note_input(pose_req_t r);
      expected_q.push_back(transform(r));
    endfunction

    function void check_result(logic signed [PT_W-1:0] got_x, logic signed [PT_W-1:0] got_y,
                               logic got_sat);
      pose_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x %0d y %0d saturated %0b", $time,
                 got_x, got_y, got_sat);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got_x !== want.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, want.x, got_x);
        errors++;
      end
      if (got_y !== want.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, want.y, got_y);
        errors++;
      end
      if (got_sat !== want.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got_sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic steady;   // when set, neither side idles

  ppt_in_if  in_ch();
  ppt_out_if out_ch();

  pose_scoreboard sb;

  planar_pose_transform_top #(
    .CORDIC_STAGES(STAGES),
    .COORD_WIDTH  (CLIP_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The result side stalls at random, except during the steady stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_x, out_ch.out_y, out_ch.saturated);
  end

  // Ends the run when no transaction has happened on either channel for a
  // long while.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL planar_pose_transform_top");
    $finish;
  end

  // Offers one point and holds it until the block takes it. Called and
  // returning at a falling edge.
  task automatic offer_point(pose_req_t r);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= r.func;
    in_ch.point_x   <= r.pt_x;
    in_ch.point_y   <= r.pt_y;
    in_ch.ref_x     <= r.ref_x;
    in_ch.ref_y     <= r.ref_y;
    in_ch.ref_angle <= r.heading;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(r);
    @(negedge clk);
  endtask

  task automatic send(logic func, logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py,
                      logic signed [PT_W-1:0] rx, logic signed [PT_W-1:0] ry,
                      logic signed [ANG_W-1:0] heading);
    pose_req_t r;
    r.func    = func;
    r.pt_x    = px;
    r.pt_y    = py;
    r.ref_x   = rx;
    r.ref_y   = ry;
    r.heading = heading;
    offer_point(r);
  endtask

  // Mixes full-range values, small and moderate coordinates and the extremes.
  function automatic logic signed [PT_W-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      return $urandom;
    else if (sel < 8)
      return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
    else if (sel == 8) begin
      unique case ($urandom_range(0, 3))
        0:       return COORD_MAX;
        1:       return COORD_MIN;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
  endfunction

  function automatic logic signed [ANG_W-1:0] rand_heading();
    int sel;
    int a;
    sel = $urandom_range(0, 9);
    if (sel < 8)
      a = int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
    else if (sel == 8)
      a = int'($urandom_range(0, 16'hFFFF));
    else
      a = (int'($urandom_range(0, 16)) - 8) * EIGHTH_TURN + int'($urandom_range(0, 2)) - 1;
    return a[ANG_W-1:0];
  endfunction

  initial begin
    pose_req_t r;
    int        k;
    sb = new();
    steady          = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_W2L;
    in_ch.point_x   = '0;
    in_ch.point_y   = '0;
    in_ch.ref_x     = '0;
    in_ch.ref_y     = '0;
    in_ch.ref_angle = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed points: extremes of the coordinates, both directions, the
    // quadrant boundaries, headings that wrap and results that clip.
    send(FUNC_W2L, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0);
    send(FUNC_W2L, COORD_MAX, COORD_MIN, 32'sd0, 32'sd0, 16'sd0);
    send(FUNC_W2L, COORD_MAX, 32'sd65536, COORD_MIN, 32'sd0, 16'sd0);
    send(FUNC_W2L, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'sd0);
    send(FUNC_L2W, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'sd0);
    send(FUNC_L2W, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 16'sd0);
    send(FUNC_W2L, 32'sd196608, 32'sd65536, 32'sd65536, -32'sd65536, DEG_90);
    send(FUNC_L2W, 32'sd196608, 32'sd65536, 32'sd65536, -32'sd65536, DEG_180);
    send(FUNC_W2L, 32'sd131072, -32'sd98304, 32'sd0, 32'sd32768, DEG_270);
    send(FUNC_L2W, 32'sd131072, -32'sd98304, 32'sd0, 32'sd32768, DEG_360);
    send(FUNC_W2L, 32'sd131072, 32'sd65536, 32'sd0, 32'sd0, -DEG_360);
    send(FUNC_W2L, 32'sd655360, 32'sd327680, 32'sd0, 32'sd0, DEG_45);
    send(FUNC_L2W, 32'sd655360, 32'sd327680, 32'sd0, 32'sd0, DEG_45 - 16'sd1);
    send(FUNC_W2L, -32'sd655360, 32'sd327680, 32'sd1, 32'sd1, -DEG_45);
    send(FUNC_L2W, -32'sd655360, 32'sd327680, 32'sd1, 32'sd1, -DEG_45 - 16'sd1);
    send(FUNC_W2L, 32'sd1000000, -32'sd2000000, 32'sd12345, 32'sd0, 16'sh7FFF);
    send(FUNC_L2W, 32'sd1000000, -32'sd2000000, 32'sd12345, 32'sd0, 16'sh8000);
    send(FUNC_W2L, COORD_MAX, COORD_MAX, 32'sd0, 32'sd0, DEG_45);
    send(FUNC_L2W, COORD_MAX, COORD_MIN, 32'sd0, 32'sd0, DEG_45);
    send(FUNC_L2W, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, -DEG_45);
    send(FUNC_W2L, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 16'sd1);
    send(FUNC_L2W, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0, -16'sd1);

    // Random points, with a long stretch in which neither side idles.
    for (k = 0; k < RANDOM_POINTS; k++) begin
      steady    = (k >= 250) && (k < 400);
      r.func    = 1'($urandom_range(0, 1));
      r.ref_x   = rand_coord();
      r.ref_y   = rand_coord();
      r.pt_x    = rand_coord();
      r.pt_y    = rand_coord();
      r.heading = rand_heading();
      // Points near the pose keep the world-to-local results in range.
      if ($urandom_range(0, 3) == 0) begin
        r.pt_x = r.ref_x + ($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        r.pt_y = r.ref_y + ($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      end
      offer_point(r);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (sb.errors == 0)
      $display("PASS planar_pose_transform_top");
    else
      $display("FAIL planar_pose_transform_top");
    $finish;
  end

endmodule
